>>> rtl/core/cst_pkg.sv
// Shared types, constants and lookup functions of the C source tokenizer.
`default_nettype none
package cst_pkg;

    localparam int KEYWORD_CHARS = 14;
    localparam int KW_COUNT      = 44;
    localparam int PN_COUNT      = 52;
    localparam int RESULT_SLOTS  = 4;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_WORD    = 4'd1,
        M_PUNCT   = 4'd2,
        M_STR     = 4'd3,
        M_ESC     = 4'd4,
        M_HEX     = 4'd5,
        M_OCT     = 4'd6,
        M_SKIP    = 4'd7,
        M_SKIPESC = 4'd8,
        M_DIR     = 4'd9
    } t_mode;

    localparam logic [2:0] CLS_KEYWORD = 3'd0;
    localparam logic [2:0] CLS_IDENT   = 3'd1;
    localparam logic [2:0] CLS_STRING  = 3'd2;
    localparam logic [2:0] CLS_PUNCT   = 3'd3;
    localparam logic [2:0] CLS_ERROR   = 3'd4;
    localparam logic [2:0] CLS_EOI     = 3'd5;

    localparam logic [5:0] ERR_PREFIX    = 6'd0;
    localparam logic [5:0] ERR_TOO_LONG  = 6'd1;
    localparam logic [5:0] ERR_UNTERM    = 6'd2;
    localparam logic [5:0] ERR_UNMATCHED = 6'd3;

    localparam logic KIND_TOKEN = 1'b0;
    localparam logic KIND_CHAR  = 1'b1;

    localparam logic [7:0] CH_LF = 8'h0A;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_input;
    } t_src_beat;

    typedef struct packed {
        logic        item_kind;
        logic [2:0]  token_class;
        logic [5:0]  token_code;
        logic [15:0] token_length;
        logic [19:0] start_line;
        logic [15:0] start_column;
        logic [7:0]  string_char;
        logic        last_of_run;
    } t_tok_beat;

    typedef logic [9:0] t_cfg_beat;

    typedef struct packed {
        t_mode                          mode;
        logic [2:0][7:0]                la;
        logic [KEYWORD_CHARS-1:0][7:0]  kb;
        logic [15:0]                    wl;
        logic [7:0]                     ev;
        logic [1:0]                     ed;
        logic [9:0]                     sc;
        logic [19:0]                    ln;
        logic [15:0]                    cn;
        logic [19:0]                    tl;
        logic [15:0]                    tc;
    } t_lex_state;

    typedef struct packed {
        t_lex_state                    s;
        t_tok_beat [RESULT_SLOTS-1:0]  r;
        logic [2:0]                    n;
        logic                          again;
    } t_work;

    // keyword spellings, right-justified, with lengths
    localparam logic [111:0] KW_TEXT [KW_COUNT] = '{
        "auto", "break", "case", "char", "const", "continue",
        "default", "do", "double", "else", "enum", "extern",
        "float", "for", "goto", "if", "inline", "int", "long",
        "register", "restrict", "return", "short", "signed",
        "sizeof", "static", "struct", "switch", "typedef",
        "union", "unsigned", "void", "volatile", "while",
        "_Alignas", "_Alignof", "_Atomic", "_Bool", "_Complex",
        "_Generic", "_Imaginary", "_Noreturn", {"_Static", "_assert"},
        {"_Thread", "_local"}
    };
    localparam logic [3:0] KW_LEN [KW_COUNT] = '{
        4'd4, 4'd5, 4'd4, 4'd4, 4'd5, 4'd8,
        4'd7, 4'd2, 4'd6, 4'd4, 4'd4, 4'd6,
        4'd5, 4'd3, 4'd4, 4'd2, 4'd6, 4'd3, 4'd4,
        4'd8, 4'd8, 4'd6, 4'd5, 4'd6,
        4'd6, 4'd6, 4'd6, 4'd6, 4'd7,
        4'd5, 4'd8, 4'd4, 4'd8, 4'd5,
        4'd8, 4'd8, 4'd7, 4'd5, 4'd8,
        4'd8, 4'd10, 4'd9, 4'd14,
        4'd13
    };

    // punctuator spellings, right-justified, with lengths
    localparam logic [31:0] PN_TEXT [PN_COUNT] = '{
        "[", "]", "(", ")", "{", "}", ".", "->", "++",
        "--", "&", "*", "+", "-", "~", "!", "/", "%",
        "<<", ">>", "<", ">", "<=", ">=", "==", "!=",
        "^", "|", "&&", "||", "?", ":", ";", "...",
        "=", "*=", "/=", "%=", "+=", "-=", "<<=", ">>=",
        "&=", "^=", "|=", ",", "<:", ":>", "<%", "%>",
        "%:", "%:%:"
    };
    localparam logic [2:0] PN_LEN [PN_COUNT] = '{
        3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd2, 3'd2,
        3'd2, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1,
        3'd2, 3'd2, 3'd1, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd1, 3'd1, 3'd2, 3'd2, 3'd1, 3'd1, 3'd1, 3'd3,
        3'd1, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd1, 3'd2, 3'd2, 3'd2, 3'd2,
        3'd2, 3'd4
    };

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_";
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return b == " " || b == 8'h09 || b == 8'h0B || b == 8'h0C || b == 8'h0D;
    endfunction

    // hex digit value, 16 for a non-digit
    function automatic logic [4:0] hex_val(input logic [7:0] b);
        logic [7:0] d;
        d = 8'd16;
        if (is_digit(b)) d = b - 8'd48;
        else if (b >= "A" && b <= "F") d = b - 8'd55;
        else if (b >= "a" && b <= "f") d = b - 8'd87;
        return d[4:0];
    endfunction

    // compare the first n bytes of p against punctuator i
    function automatic logic pn_head_match(input int i, input logic [3:0][7:0] p,
                                           input logic [2:0] n);
        logic m;
        int   sh;
        m = 1'b1;
        for (int j = 0; j < 4; j++) begin
            if (3'(j) < n && 3'(j) < PN_LEN[i]) begin
                sh = 8 * (int'(PN_LEN[i]) - 1 - j);
                m  = m && (p[j] == 8'(PN_TEXT[i] >> sh));
            end
        end
        return m;
    endfunction

    // exact punctuator of n bytes: bit 6 found, low bits index
    function automatic logic [6:0] pn_exact(input logic [3:0][7:0] p, input logic [2:0] n);
        logic [6:0] res;
        res = '0;
        for (int i = 0; i < PN_COUNT; i++) begin
            if (!res[6] && PN_LEN[i] == n && pn_head_match(i, p, n))
                res = {1'b1, 6'(i)};
        end
        return res;
    endfunction

    // some longer punctuator starts with these n bytes
    function automatic logic pn_prefix(input logic [3:0][7:0] p, input logic [2:0] n);
        logic any;
        any = 1'b0;
        for (int i = 0; i < PN_COUNT; i++)
            if (PN_LEN[i] > n && pn_head_match(i, p, n)) any = 1'b1;
        return any;
    endfunction

    function automatic logic is_punct_char(input logic [7:0] b);
        logic [6:0] r;
        r = pn_exact({24'd0, b}, 3'd1);
        return r[6];
    endfunction

    // keyword lookup: bit 6 found, low bits index
    function automatic logic [6:0] kw_lookup(input logic [KEYWORD_CHARS-1:0][7:0] kb,
                                             input logic [15:0] wl);
        logic [6:0] res;
        logic       m;
        int         sh;
        res = '0;
        for (int i = 0; i < KW_COUNT; i++) begin
            m = (wl == 16'(KW_LEN[i]));
            for (int j = 0; j < KEYWORD_CHARS; j++) begin
                if (4'(j) < KW_LEN[i]) begin
                    sh = 8 * (int'(KW_LEN[i]) - 1 - j);
                    m  = m && (kb[j] == 8'(KW_TEXT[i] >> sh));
                end
            end
            if (m && !res[6]) res = {1'b1, 6'(i)};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

>>> rtl/core/cst_chan_if.sv
// Valid/ready channel carrying one payload beat of a given type.
`default_nettype none
interface cst_chan_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> rtl/core/c_source_tokenizer.sv
// C source tokenizer: lexer state, combinational byte decode and result queue.
// Results: the results of an accepted byte are written into the result queue, whose head
//   drives o_tok from registers, so they are offered behind any results already queued.
// Throughput: one byte per cycle while the 8-deep result queue has four free places;
//   results leave one per cycle while o_tok.ready is high.
// Reset (synchronous, active low) returns the lexer to idle at line 0, column 0,
//   empties the queue and sets string_limit to 512.
`default_nettype none
module c_source_tokenizer
    import cst_pkg::*;
#(
    parameter int MAX_STRING_CHARS = 512
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    cst_chan_if.sink     i_src,
    cst_chan_if.sink     i_cfg,
    cst_chan_if.source   o_tok
);

    localparam int QDEPTH = 8;
    localparam int QW     = $clog2(QDEPTH);
    localparam logic [12:0] MAX_LIM = 13'(MAX_STRING_CHARS);

    t_lex_state       r_state, n_state;
    t_tok_beat        r_queue [QDEPTH];
    logic [QW-1:0]    r_head, r_tail;
    logic [QW:0]      r_count, n_count;
    logic [9:0]       r_string_limit;

    t_work            w_pass;
    logic [9:0]       w_lim;
    logic             w_take, w_pop;

    function automatic logic [15:0] sat16(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic logic [19:0] sat20(input logic [19:0] v);
        return (v == 20'hFFFFF) ? v : v + 20'd1;
    endfunction

    function automatic t_work emit(input t_work w, input logic kind, input logic [2:0] cls,
                                   input logic [5:0] code, input logic [15:0] len,
                                   input logic [7:0] ch);
        t_work o;
        o = w;
        if (o.n < 3'(RESULT_SLOTS)) begin
            o.r[o.n[1:0]] = '{kind, cls, code, len, o.s.tl, o.s.tc, ch, 1'b0};
            o.n = o.n + 3'd1;
        end
        return o;
    endfunction

    // split pending punctuator bytes by longest match
    function automatic t_work settle(input t_work w, input logic [3:0][7:0] p_in,
                                     input logic [2:0] n_in, input logic fin);
        t_work             o;
        logic [3:0][7:0]   p;
        logic [2:0]        n, k;
        logic [6:0]        hit, e;
        logic [16:0]       tsum;
        logic              done;
        o = w;
        p = p_in;
        n = n_in;
        done = 1'b0;
        for (int it = 0; it < 4; it++) begin
            if (!done && n != 3'd0) begin
                if (!fin && pn_prefix(p, n)) begin
                    done = 1'b1;
                end else begin
                    k = 3'd0;
                    e = '0;
                    for (int kk = 4; kk >= 1; kk--) begin
                        if (k == 3'd0 && 3'(kk) <= n) begin
                            hit = pn_exact(p, 3'(kk));
                            if (hit[6]) begin
                                k = 3'(kk);
                                e = hit;
                            end
                        end
                    end
                    if (k == 3'd0) begin
                        o = emit(o, KIND_TOKEN, CLS_ERROR, ERR_UNMATCHED, 16'd1, 8'd0);
                        k = 3'd1;
                    end else begin
                        o = emit(o, KIND_TOKEN, CLS_PUNCT, e[5:0], 16'(k), 8'd0);
                    end
                    tsum   = {1'b0, o.s.tc} + 17'(k);
                    o.s.tc = tsum[16] ? 16'hFFFF : tsum[15:0];
                    p      = p >> (8 * int'(k));
                    n      = n - k;
                end
            end
        end
        if (n > 3'd3) n = 3'd3;
        o.s.la   = p[2:0];
        o.s.wl   = 16'(n);
        o.s.mode = (n == 3'd0) ? M_IDLE : M_PUNCT;
        return o;
    endfunction

    function automatic t_work word_emit(input t_work w);
        logic [6:0] hit;
        hit = (w.s.wl <= 16'(KEYWORD_CHARS)) ? kw_lookup(w.s.kb, w.s.wl) : 7'd0;
        if (hit[6]) return emit(w, KIND_TOKEN, CLS_KEYWORD, hit[5:0], w.s.wl, 8'd0);
        return emit(w, KIND_TOKEN, CLS_IDENT, 6'd0, w.s.wl, 8'd0);
    endfunction

    function automatic t_work enter_skip(input t_work w, input logic [7:0] term,
                                         input logic [7:0] cause);
        t_work o;
        o = w;
        o.s.mode  = M_SKIP;
        o.s.la[0] = term;
        o.s.ev    = cause;
        return o;
    endfunction

    // one pass of the lexer over byte b
    function automatic t_work run(input t_work w, input logic [7:0] b, input logic [9:0] lim);
        t_work           o;
        logic [3:0][7:0] p;
        logic [2:0]      n;
        logic [8:0]      v;
        logic [4:0]      hv;
        logic [10:0]     ov;
        o = w;
        o.again = 1'b0;
        p = '0;
        case (o.s.mode)
            M_IDLE: begin
                if (!(b == CH_LF || is_blank(b))) begin
                    o.s.tl = o.s.ln;
                    o.s.tc = o.s.cn;
                    if (b == "#") begin
                        o.s.mode = M_DIR;
                    end else if (is_letter(b)) begin
                        o.s.mode  = M_WORD;
                        o.s.kb[0] = b;
                        o.s.wl    = 16'd1;
                    end else if (b == 8'h22) begin
                        o.s.mode = M_STR;
                        o.s.wl   = 16'd1;
                        o.s.sc   = 10'd0;
                    end else if (is_punct_char(b)) begin
                        p[0] = b;
                        o = settle(o, p, 3'd1, 1'b0);
                    end else begin
                        o = emit(o, KIND_TOKEN, CLS_ERROR, ERR_UNMATCHED, 16'd1, 8'd0);
                    end
                end
            end
            M_WORD: begin
                if ((b == 8'h22 || b == 8'h27) && o.s.wl == 16'd1 &&
                    (o.s.kb[0] inside {"u", "U", "L"})) begin
                    o = enter_skip(o, b, 8'd0);
                    o.s.wl = 16'd2;
                end else if (b == 8'h22 && o.s.wl == 16'd2 && o.s.kb[0] == "u" &&
                             o.s.kb[1] == "8") begin
                    o = enter_skip(o, b, 8'd0);
                    o.s.wl = 16'd3;
                end else if (is_letter(b) || is_digit(b)) begin
                    if (o.s.wl < 16'(KEYWORD_CHARS)) o.s.kb[o.s.wl[3:0]] = b;
                    o.s.wl = sat16(o.s.wl);
                end else begin
                    o = word_emit(o);
                    o.s.mode = M_IDLE;
                    o.again  = 1'b1;
                end
            end
            M_PUNCT: begin
                n = (o.s.wl > 16'd3) ? 3'd3 : o.s.wl[2:0];
                p[2:0] = o.s.la;
                for (int j = 0; j < 3; j++) if (3'(j) >= n) p[j] = 8'd0;
                if (is_punct_char(b)) begin
                    p[n[1:0]] = b;
                    o = settle(o, p, n + 3'd1, 1'b0);
                end else begin
                    o = settle(o, p, n, 1'b1);
                    o.s.mode = M_IDLE;
                    o.again  = 1'b1;
                end
            end
            M_STR: begin
                if (b == 8'h22) begin
                    o.s.wl = sat16(o.s.wl);
                    o = emit(o, KIND_TOKEN, CLS_STRING, 6'd0, o.s.wl, 8'd0);
                    o.s.mode = M_IDLE;
                end else if (b == CH_LF) begin
                    o = emit(o, KIND_TOKEN, CLS_ERROR, ERR_UNTERM, o.s.wl, 8'd0);
                    o.s.mode = M_IDLE;
                end else if (o.s.sc >= lim) begin
                    o = enter_skip(o, 8'h22, 8'(ERR_TOO_LONG));
                    o.again = 1'b1;
                end else begin
                    o.s.wl = sat16(o.s.wl);
                    o.s.sc = o.s.sc + 10'd1;
                    if (b == 8'h5C) o.s.mode = M_ESC;
                    else o = emit(o, KIND_CHAR, CLS_STRING, 6'd0, 16'd0, b);
                end
            end
            M_ESC: begin
                case (b)
                    8'h27:        v = 9'h027;
                    8'h22:        v = 9'h022;
                    "?":          v = 9'h03F;
                    8'h5C:        v = 9'h05C;
                    "v":          v = 9'd11;
                    "f":          v = 9'd12;
                    "r":          v = 9'd13;
                    "t":          v = 9'd9;
                    "n", CH_LF:   v = 9'd10;
                    "a":          v = 9'd7;
                    "b":          v = 9'd8;
                    default:      v = 9'd256;
                endcase
                if (!v[8]) begin
                    o.s.wl = sat16(o.s.wl);
                    o = emit(o, KIND_CHAR, CLS_STRING, 6'd0, 16'd0, v[7:0]);
                    o.s.mode = M_STR;
                end else if (b == "x" || b == "X") begin
                    o.s.wl   = sat16(o.s.wl);
                    o.s.ev   = 8'd0;
                    o.s.ed   = 2'd0;
                    o.s.mode = M_HEX;
                end else if (b >= "0" && b <= "7") begin
                    o.s.wl   = sat16(o.s.wl);
                    o.s.ev   = b - 8'd48;
                    o.s.ed   = 2'd1;
                    o.s.mode = M_OCT;
                end else begin
                    o = emit(o, KIND_CHAR, CLS_STRING, 6'd0, 16'd0, 8'h5C);
                    o.s.mode = M_STR;
                    o.again  = 1'b1;
                end
            end
            M_HEX: begin
                hv = hex_val(b);
                if (!hv[4]) begin
                    o.s.wl = sat16(o.s.wl);
                    o.s.ev = {o.s.ev[3:0], hv[3:0]};
                    o.s.ed = (o.s.ed == 2'd3) ? 2'd3 : o.s.ed + 2'd1;
                end else begin
                    o = emit(o, KIND_CHAR, CLS_STRING, 6'd0, 16'd0, o.s.ev);
                    o.s.mode = M_STR;
                    o.again  = 1'b1;
                end
            end
            M_OCT: begin
                if (b >= "0" && b <= "7") begin
                    o.s.wl = sat16(o.s.wl);
                    ov     = {o.s.ev, 3'd0} + 11'(b - 8'd48);
                    o.s.ev = ov[7:0];
                    o.s.ed = (o.s.ed == 2'd3) ? 2'd3 : o.s.ed + 2'd1;
                    if (o.s.ed == 2'd3) begin
                        o = emit(o, KIND_CHAR, CLS_STRING, 6'd0, 16'd0, o.s.ev);
                        o.s.mode = M_STR;
                    end
                end else begin
                    o = emit(o, KIND_CHAR, CLS_STRING, 6'd0, 16'd0, o.s.ev);
                    o.s.mode = M_STR;
                    o.again  = 1'b1;
                end
            end
            M_SKIP: begin
                if (b == CH_LF) begin
                    o = emit(o, KIND_TOKEN, CLS_ERROR, o.s.ev[5:0], o.s.wl, 8'd0);
                    o.s.mode = M_IDLE;
                end else begin
                    o.s.wl = sat16(o.s.wl);
                    if (b == 8'h5C) begin
                        o.s.mode = M_SKIPESC;
                    end else if (b == o.s.la[0]) begin
                        o = emit(o, KIND_TOKEN, CLS_ERROR, o.s.ev[5:0], o.s.wl, 8'd0);
                        o.s.mode = M_IDLE;
                    end
                end
            end
            M_SKIPESC: begin
                o.s.wl   = sat16(o.s.wl);
                o.s.mode = M_SKIP;
            end
            M_DIR: begin
                if (b == CH_LF) o.s.mode = M_IDLE;
            end
            default: begin
                o.s.mode = M_IDLE;
                o.again  = 1'b1;
            end
        endcase
        return o;
    endfunction

    // flush pending work at the final byte, then the end-of-input beat
    function automatic t_work finish(input t_work w);
        t_work           o;
        logic [3:0][7:0] p;
        logic [2:0]      n;
        o = w;
        p = '0;
        case (o.s.mode)
            M_WORD: o = word_emit(o);
            M_PUNCT: begin
                n = (o.s.wl > 16'd3) ? 3'd3 : o.s.wl[2:0];
                p[2:0] = o.s.la;
                for (int j = 0; j < 3; j++) if (3'(j) >= n) p[j] = 8'd0;
                o = settle(o, p, n, 1'b1);
            end
            M_HEX, M_OCT: begin
                o = emit(o, KIND_CHAR, CLS_STRING, 6'd0, 16'd0, o.s.ev);
                o = emit(o, KIND_TOKEN, CLS_ERROR, ERR_UNTERM, o.s.wl, 8'd0);
            end
            M_STR, M_ESC: o = emit(o, KIND_TOKEN, CLS_ERROR, ERR_UNTERM, o.s.wl, 8'd0);
            M_SKIP, M_SKIPESC:
                o = emit(o, KIND_TOKEN, CLS_ERROR, o.s.ev[5:0], o.s.wl, 8'd0);
            default: ;
        endcase
        o.s.tl = o.s.ln;
        o.s.tc = o.s.cn;
        o = emit(o, KIND_TOKEN, CLS_EOI, 6'd0, 16'd0, 8'd0);
        o.s = '0;
        o.s.mode = M_IDLE;
        return o;
    endfunction

    // limit in force for string length
    assign w_lim = ({3'd0, r_string_limit} > MAX_LIM) ? MAX_LIM[9:0] : r_string_limit;

    // decode one byte: up to three lexer passes, position update, end of input
    always_comb begin
        t_work w;
        logic [7:0] b;
        w = '0;
        w.s = r_state;
        b = i_src.data.in_byte;
        w = run(w, b, w_lim);
        if (w.again) w = run(w, b, w_lim);
        if (w.again) w = run(w, b, w_lim);
        if (b == CH_LF) begin
            w.s.ln = sat20(w.s.ln);
            w.s.cn = 16'd0;
        end else begin
            w.s.cn = sat16(w.s.cn);
        end
        if (i_src.data.end_of_input) w = finish(w);
        if (w.n != 3'd0) w.r[2'(w.n - 3'd1)].last_of_run = 1'b1;
        w_pass = w;
    end

    // handshakes
    assign i_src.ready = (r_count <= (QW+1)'(QDEPTH - RESULT_SLOTS));
    assign i_cfg.ready = 1'b1;
    assign w_take      = i_src.valid && i_src.ready;
    assign o_tok.valid = (r_count != '0);
    assign o_tok.data  = r_queue[r_head];
    assign w_pop       = o_tok.valid && o_tok.ready;

    assign n_state = w_take ? w_pass.s : r_state;
    assign n_count = r_count + (w_take ? (QW+1)'(w_pass.n) : '0) - (w_pop ? (QW+1)'(1) : '0);

    // hold lexer state, queue pointers and limit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= '0;
            r_head         <= '0;
            r_tail         <= '0;
            r_count        <= '0;
            r_string_limit <= 10'd512;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_pop) r_head <= r_head + QW'(1);
            if (w_take) r_tail <= r_tail + QW'(w_pass.n);
            if (i_cfg.valid && i_cfg.ready) r_string_limit <= i_cfg.data;
        end
    end

    // write the beats of an accepted byte into the queue
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            for (int i = 0; i < RESULT_SLOTS; i++)
                if (3'(i) < w_pass.n) r_queue[r_tail + QW'(i)] <= w_pass.r[i];
        end
    end

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (QW+1)'(QDEPTH))
        else $error("result queue overfilled");

    a_eoi_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_take && i_src.data.end_of_input) |=>
            (r_state.mode == M_IDLE && r_state.ln == 20'd0 && r_state.cn == 16'd0))
        else $error("lexer state not cleared after final byte");

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> (r_count == '0 && r_state.mode == M_IDLE))
        else $error("queue or lexer not idle after reset");

endmodule
`default_nettype wire
